>>> rtl/kss_pkg.sv
// Shared types, codes and sizes for the shared-store stack block.
// No dependencies; used by kss_store and k_stacks_shared_store.
package kss_pkg;

    // Store geometry
    localparam int NUM_STACKS  = 4;
    localparam int STORE_DEPTH = 16;

    // Slot index, link (index plus null code) and stack index widths
    localparam int IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LINK_W = $clog2(STORE_DEPTH + 1);
    localparam int TOP_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    // Field widths
    localparam int SID_W  = 2;
    localparam int DATA_W = 32;

    // Null link
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(STORE_DEPTH);

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic signed [DATA_W-1:0] UNDERFLOW_VALUE = 32'sh7FFF_FFFF;

    // Request and result payloads
    typedef struct packed {
        logic                     op;
        logic [SID_W-1:0]         stack_id;
        logic signed [DATA_W-1:0] push_value;
    } t_request;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] pop_value;
        logic                     store_full;
        logic                     stack_empty;
    } t_result;

    // Write port of the link/data store
    typedef struct packed {
        logic                     link_we;
        logic                     data_we;
        logic [IDX_W-1:0]         addr;
        logic [LINK_W-1:0]        link;
        logic signed [DATA_W-1:0] data;
    } t_store_wr;

    // Link an entry holds before it is first written: next slot, last one null
    function automatic logic [LINK_W-1:0] f_init_link(input logic [IDX_W-1:0] idx);
        logic [LINK_W-1:0] lnk;
        if (int'(idx) == STORE_DEPTH - 1) begin
            lnk = LINK_NULL;
        end else begin
            lnk = LINK_W'(int'(idx) + 1);
        end
        return lnk;
    endfunction

    function automatic logic f_is_null(input logic [LINK_W-1:0] lnk);
        return int'(lnk) >= STORE_DEPTH;
    endfunction

endpackage

>>> rtl/k_stacks_shared_store.sv
// Several LIFO stacks in one shared slot store with a free list.
// The result strobe o_valid follows an accepted request through r_busy and r_valid.
// A new request is not taken while busy; busy is high for the cycle after accept,
// set by the read of the link/data memories followed by their write-back.
// Reset: all stacks empty, free list 0..last, ready in the first cycle after reset.
// Results cannot be stalled; each is shown for one cycle. Depends on kss_pkg, kss_store.
module k_stacks_shared_store
    import kss_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_request i_req,
    output logic     o_valid,
    output t_result  o_res
);

    logic                     r_busy;
    logic                     r_op;
    logic [SID_W-1:0]         r_sid;
    logic signed [DATA_W-1:0] r_val;
    logic [LINK_W-1:0]        r_slot;
    logic [LINK_W-1:0]        r_free;
    logic [LINK_W-1:0]        r_tops [NUM_STACKS];
    logic                     r_valid;
    t_result                  r_res;

    logic                     accept;
    logic                     sid_ok_in;
    logic [LINK_W-1:0]        n_slot;
    logic [LINK_W-1:0]        st_link;
    logic signed [DATA_W-1:0] st_data;
    t_store_wr                wr;
    logic                     sid_ok;
    logic                     push_ok;
    logic                     pop_ok;
    t_result                  n_res;
    logic [LINK_W-1:0]        cur_top;

    assign accept    = start && !r_busy;
    assign busy      = r_busy;
    assign sid_ok_in = int'(i_req.stack_id) < NUM_STACKS;

    // Slot touched by the request: free head for push or an unknown stack, stack top for pop
    always_comb begin
        if (i_req.op == OP_PUSH || !sid_ok_in) begin
            n_slot = r_free;
        end else begin
            n_slot = r_tops[i_req.stack_id[TOP_W-1:0]];
        end
    end

    kss_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (n_slot[IDX_W-1:0]),
        .i_wr      (wr),
        .o_link    (st_link),
        .o_data    (st_data)
    );

    // Request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_req.op;
            r_sid  <= i_req.stack_id;
            r_val  <= i_req.push_value;
            r_slot <= n_slot;
        end
    end

    // Write-back step while r_busy: decide, write back, build the result
    assign sid_ok  = int'(r_sid) < NUM_STACKS;
    assign cur_top = r_tops[r_sid[TOP_W-1:0]];
    assign push_ok = r_busy && (r_op == OP_PUSH) && sid_ok && !f_is_null(r_slot);
    assign pop_ok  = r_busy && (r_op == OP_POP) && sid_ok && !f_is_null(r_slot);

    always_comb begin
        wr.link_we = push_ok || pop_ok;
        wr.data_we = push_ok;
        wr.addr    = r_slot[IDX_W-1:0];
        wr.link    = push_ok ? cur_top : r_free;
        wr.data    = r_val;
    end

    always_comb begin
        n_res.pop_value = '0;
        if (r_op == OP_PUSH) begin
            n_res.status      = push_ok ? ST_DONE : ST_OVERFLOW;
            n_res.store_full  = push_ok ? f_is_null(st_link) : f_is_null(r_free);
            n_res.stack_empty = push_ok ? 1'b0 : (!sid_ok || f_is_null(cur_top));
        end else begin
            n_res.status      = pop_ok ? ST_DONE : ST_UNDERFLOW;
            n_res.pop_value   = pop_ok ? st_data : UNDERFLOW_VALUE;
            n_res.store_full  = pop_ok ? 1'b0 : f_is_null(r_free);
            n_res.stack_empty = pop_ok ? f_is_null(st_link) : 1'b1;
        end
    end

    // Control state: busy flag, free head, stack tops, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_free  <= '0;
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_tops[i] <= LINK_NULL;
            end
        end else begin
            r_busy  <= accept;
            r_valid <= r_busy;
            if (push_ok) begin
                r_free                     <= st_link;
                r_tops[r_sid[TOP_W-1:0]]   <= r_slot;
            end else if (pop_ok) begin
                r_free                     <= r_slot;
                r_tops[r_sid[TOP_W-1:0]]   <= st_link;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Busy lasts exactly one cycle per request
    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("busy held longer than one cycle");

    // Every request gives exactly one strobe, in the cycle after busy
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $past(r_busy))
        else $error("result strobe not tied to request");

    // Store writes happen only in the write-back cycle
    a_wr_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.link_we |-> r_busy)
        else $error("store write outside write-back cycle");

    // A successful push advances the free head to the link read from its slot
    a_free_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_ok |=> r_free == $past(st_link))
        else $error("free head not advanced on push");

endmodule

>>> rtl/kss_store.sv
// Link store and data store: synchronous memories, one read port, one write port.
// Unwritten link entries read as the initial free chain. Depends on kss_pkg.
module kss_store
    import kss_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [IDX_W-1:0]         i_rd_addr,
    input  t_store_wr                i_wr,
    output logic [LINK_W-1:0]        o_link,
    output logic signed [DATA_W-1:0] o_data
);

    logic [LINK_W-1:0]        link_mem [STORE_DEPTH];
    logic signed [DATA_W-1:0] data_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0]   r_link_vld;

    logic [LINK_W-1:0]        r_link_q;
    logic signed [DATA_W-1:0] r_data_q;
    logic                     r_vld_q;
    logic [IDX_W-1:0]         r_rd_addr;

    // Memory arrays: write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.link_we) begin
            link_mem[i_wr.addr] <= i_wr.link;
        end
        if (i_wr.data_we) begin
            data_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_link_q  <= link_mem[i_rd_addr];
            r_data_q  <= data_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // Written flags: reset restores the initial free chain at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
            r_vld_q    <= 1'b0;
        end else begin
            if (i_wr.link_we) begin
                r_link_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_vld_q <= r_link_vld[i_rd_addr];
            end
        end
    end

    assign o_link = r_vld_q ? r_link_q : f_init_link(r_rd_addr);
    assign o_data = r_data_q;

    // Reads and writes never share a cycle
    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd_en && (i_wr.link_we || i_wr.data_we)))
        else $error("store read and write in the same cycle");

    // Data is only written together with its link (push)
    a_data_with_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.data_we |-> i_wr.link_we)
        else $error("data write without link write");

    // A written entry stays marked as written
    a_vld_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.link_we |=> r_link_vld[$past(i_wr.addr)])
        else $error("link entry lost its written flag");

endmodule

>>> dv/tb.sv
// Self-checking bench for k_stacks_shared_store: a queue-fed request driver,
// a result monitor and a predictor of the linked stacks and free list.
// Depends on kss_pkg and the k_stacks_shared_store RTL.
module tb;
    import kss_pkg::*;

    // Request waiting to be driven, with the sender idle chance for its phase
    typedef struct {
        t_request    req;
        int unsigned idle_pct;
    } t_queued_req;

    logic     i_clk;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_request i_req   = '0;
    logic     busy;
    logic     o_valid;
    t_result  o_res;

    t_queued_req request_queue[$];
    t_result     pending_results[$];
    int unsigned n_mismatch = 0;

    // Predicted contents of the shared store
    logic signed [DATA_W-1:0] slot_data[STORE_DEPTH];
    logic [LINK_W-1:0]        chain_link[STORE_DEPTH];
    logic [LINK_W-1:0]        stack_top[NUM_STACKS];
    logic [LINK_W-1:0]        free_list_head;

    k_stacks_shared_store dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    function automatic bit link_ends(input logic [LINK_W-1:0] lnk);
        return int'(lnk) >= STORE_DEPTH;
    endfunction

    // Apply one request to the predicted store and return its result
    function automatic t_result predict_stack_op(input t_request r);
        t_result           res;
        logic [LINK_W-1:0] slot;
        bit                known_stack;
        known_stack   = int'(r.stack_id) < NUM_STACKS;
        res.status    = ST_DONE;
        res.pop_value = '0;
        if (r.op == OP_PUSH) begin
            if (!known_stack || link_ends(free_list_head)) begin
                res.status = ST_OVERFLOW;
            end else begin
                slot                           = free_list_head;
                free_list_head                 = chain_link[slot[IDX_W-1:0]];
                chain_link[slot[IDX_W-1:0]]    = stack_top[r.stack_id];
                stack_top[r.stack_id]          = slot;
                slot_data[slot[IDX_W-1:0]]     = r.push_value;
            end
        end else begin
            if (!known_stack || link_ends(stack_top[r.stack_id])) begin
                res.status    = ST_UNDERFLOW;
                res.pop_value = UNDERFLOW_VALUE;
            end else begin
                slot                        = stack_top[r.stack_id];
                stack_top[r.stack_id]       = chain_link[slot[IDX_W-1:0]];
                chain_link[slot[IDX_W-1:0]] = free_list_head;
                free_list_head              = slot;
                res.pop_value               = slot_data[slot[IDX_W-1:0]];
            end
        end
        res.store_full  = link_ends(free_list_head);
        res.stack_empty = known_stack ? link_ends(stack_top[r.stack_id]) : 1'b1;
        return res;
    endfunction

    // Random data half the time, the extremes, zero and minus one the other half
    function automatic logic signed [DATA_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(7);
        if (sel == 0) return 32'sh8000_0000;
        if (sel == 1) return UNDERFLOW_VALUE;
        if (sel == 2) return '0;
        if (sel == 3) return -32'sd1;
        return $urandom();
    endfunction

    task automatic add_request(input logic op, input int unsigned sid,
                               input logic signed [DATA_W-1:0] val,
                               input int unsigned idle_pct);
        t_queued_req q;
        q.req.op         = op;
        q.req.stack_id   = sid[SID_W-1:0];
        q.req.push_value = val;
        q.idle_pct       = idle_pct;
        request_queue.push_back(q);
    endtask

    // Driver: predict on accept, then present the next request or idle
    always @(posedge i_clk) begin
        bit go;
        go = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                pending_results.push_back(predict_stack_op(i_req));
                void'(request_queue.pop_front());
            end
            if (request_queue.size() != 0) begin
                if (start && busy)
                    go = 1'b1;
                else
                    go = $urandom_range(99) >= request_queue[0].idle_pct;
            end
            start <= go;
            if (go)
                i_req <= request_queue[0].req;
        end
    end

    // Monitor: compare every strobed result with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("%0t: result with no request outstanding", $time);
            end else begin
                want = pending_results.pop_front();
                if (o_res.status !== want.status || o_res.pop_value !== want.pop_value ||
                    o_res.store_full !== want.store_full ||
                    o_res.stack_empty !== want.stack_empty) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("%0t: mismatch: expected status %0d value %0d full %b empty %b,",
                                 $time, want.status, want.pop_value, want.store_full,
                                 want.stack_empty,
                                 " got status %0d value %0d full %b empty %b",
                                 o_res.status, o_res.pop_value, o_res.store_full,
                                 o_res.stack_empty);
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int unsigned idle_pct;
        int unsigned push_bias;
        int unsigned hot_sid;
        int unsigned sid;
        logic        op;

        // Predictor state after reset
        for (int i = 0; i < STORE_DEPTH; i++) begin
            slot_data[i]  = '0;
            chain_link[i] = (i == STORE_DEPTH - 1) ? LINK_NULL : LINK_W'(i + 1);
        end
        for (int i = 0; i < NUM_STACKS; i++)
            stack_top[i] = LINK_NULL;
        free_list_head = '0;

        // Directed: underflow on empty, extremes, fill to overflow, drain stack 0 to empty
        add_request(OP_POP, 0, '0, 0);
        add_request(OP_PUSH, 0, 32'sh8000_0000, 0);
        add_request(OP_PUSH, 1, UNDERFLOW_VALUE, 0);
        add_request(OP_PUSH, 2, '0, 0);
        add_request(OP_PUSH, 3, -32'sd1, 0);
        add_request(OP_POP, 1, '0, 0);
        add_request(OP_PUSH, 1, 32'sh5555_5555, 0);
        add_request(OP_PUSH, 1, 32'shAAAA_AAAA, 0);
        for (int k = 0; k < STORE_DEPTH - 5; k++)
            add_request(OP_PUSH, k % NUM_STACKS, 32'sh1234_5678 ^ k, 0);
        add_request(OP_PUSH, 2, 32'sh0F0F_0F0F, 0);
        for (int k = 0; k < 5; k++)
            add_request(OP_POP, 0, $urandom(), 0);

        // Random: blocks that lean toward filling, draining or neither, often on one stack
        push_bias = 50;
        hot_sid   = 0;
        for (int n = 0; n < 1925; n++) begin
            if (n % 32 == 0) begin
                push_bias = ($urandom_range(2) == 0) ? 20 : (($urandom_range(1) == 0) ? 50 : 80);
                hot_sid   = $urandom_range(NUM_STACKS - 1);
            end
            idle_pct = (n < 640) ? 0 : ((n < 1280) ? 58 : 29);
            op       = ($urandom_range(99) < push_bias) ? OP_PUSH : OP_POP;
            sid      = ($urandom_range(1) == 0) ? hot_sid : $urandom_range(3);
            add_request(op, sid, pick_value(), idle_pct);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() != 0 || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (n_mismatch == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/kss_pkg.sv
rtl/kss_store.sv
rtl/k_stacks_shared_store.sv
dv/tb.sv
